FILE: rtl/core/pfrr_pkg.sv
// Shared types, constants and a helper function of the per-flow round-robin path selector.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pfrr_pkg;

   localparam int MAX_PATHS    = 16;
   localparam int FLOW_ENTRIES = 1024;

   localparam int PATH_IDX_W = $clog2(MAX_PATHS);
   localparam int COUNT_W    = $clog2(MAX_PATHS + 1);
   localparam int FLOW_W     = $clog2(FLOW_ENTRIES);
   localparam int WEIGHT_W   = 8;
   localparam int ADDR_W     = 32;
   localparam int LFSR_W     = 16;
   localparam int DIV_CNT_W  = $clog2(LFSR_W);
   localparam int CMP_W      = (COUNT_W > WEIGHT_W) ? COUNT_W : WEIGHT_W;

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   localparam int REQ_BITS    = FLOW_W + WEIGHT_W + ADDR_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - REQ_BITS;

   localparam int RSP_BITS    = ADDR_W + PATH_IDX_W + 1 + 2 + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_ROUTE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_TRUNC = 2'd2
   } status_type;

   // Packed structs list the highest field first.
   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [ADDR_W-1:0]    address;
      logic [WEIGHT_W-1:0]  weight;
      logic [FLOW_W-1:0]    flow_id;
   } req_data_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]  pad;
      logic [COUNT_W-1:0]    list_length;
      status_type            status;
      logic                  flow_known;
      logic [PATH_IDX_W-1:0] path_index;
      logic [ADDR_W-1:0]     core_address;
   } rsp_data_type;

   typedef struct packed {
      logic                  valid;
      logic [PATH_IDX_W-1:0] idx;
   } flow_entry_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic lookup;
      logic div_step;
      logic path_read;
      logic append_step;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic empty;
      logic known;
      logic div_last;
      logic copies_zero;
      logic rsp_free;
   } dp_stat_type;

   // One step of the right-shifting Galois LFSR.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] value);
      logic [LFSR_W-1:0] shifted;
      shifted = value >> 1;
      return value[0] ? (shifted ^ LFSR_TAPS) : shifted;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pfrr_ctrl.sv
// Controller state machine of the path selector: sequences the flow-table clearing pass,
// appends, route lookups and the result hand-off. Depends on pfrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfrr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pfrr_pkg::opcode_type   req_opcode,
   input  pfrr_pkg::dp_stat_type  stat,
   output pfrr_pkg::ctrl_cmd_type cmd
);
   import pfrr_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPEND,
      ST_FLOW_RD,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_PATH_RD,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_opcode == OP_ROUTE) ? ST_FLOW_RD : ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (stat.copies_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.append_step = 1'b1;
            end
         end
         ST_FLOW_RD: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (stat.empty) begin
               state_in = ST_DONE;
            end else if (stat.known) begin
               state_in = ST_PATH_RD;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_PATH_RD;
         end
         ST_PATH_RD: begin
            cmd.path_read = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/pfrr_dpath.sv
// Datapath of the path selector: path list and flow table memories, LFSR, the bit-serial
// remainder unit and the result register. Driven by pfrr_ctrl; depends on pfrr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfrr_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  pfrr_pkg::ctrl_cmd_type        cmd,
   output pfrr_pkg::dp_stat_type         stat,
   input  pfrr_pkg::opcode_type          req_opcode,
   input  pfrr_pkg::req_data_type        req_data,
   input  logic                          csr_write,
   input  logic [pfrr_pkg::LFSR_W-1:0]   csr_seed,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pfrr_pkg::rsp_data_type        rsp_data
);
   import pfrr_pkg::*;

   // Memories.
   logic [ADDR_W-1:0] path_mem [MAX_PATHS];
   flow_entry_type    flow_mem [FLOW_ENTRIES];

   // Control registers.
   logic [COUNT_W-1:0]    count_ff;
   logic [LFSR_W-1:0]     lfsr_ff;
   logic [FLOW_W-1:0]     clr_ff;
   logic                  rsp_valid_ff;

   // Per-request working registers.
   opcode_type            op_ff;
   logic [FLOW_W-1:0]     flow_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [COUNT_W-1:0]    copies_ff;
   status_type            stat_ff;
   logic [PATH_IDX_W-1:0] idx_ff;
   logic                  known_ff;
   logic [COUNT_W-1:0]    rem_ff;
   logic [LFSR_W-1:0]     div_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   flow_entry_type        flow_rd_ff;
   logic [ADDR_W-1:0]     path_rd_ff;
   rsp_data_type          rsp_data_ff;

   logic [COUNT_W-1:0]    space_in;
   logic                  trunc_in;
   logic [COUNT_W-1:0]    copies_in;
   logic [LFSR_W-1:0]     lfsr_adv_in;
   logic [COUNT_W:0]      rem_shift;
   logic [COUNT_W:0]      rem_diff;
   logic [COUNT_W-1:0]    rem_in;
   logic [COUNT_W-1:0]    idx_inc;
   logic [PATH_IDX_W-1:0] next_idx_in;
   logic                  route_ok;

   // Copies that still fit in the list.
   assign space_in  = COUNT_W'(MAX_PATHS) - count_ff;
   assign trunc_in  = CMP_W'(req_data.weight) > CMP_W'(space_in);
   assign copies_in = trunc_in ? space_in : COUNT_W'(req_data.weight);

   assign lfsr_adv_in = lfsr_next(lfsr_ff);

   // Restoring remainder step: shift in one dividend bit, subtract the list length if it fits.
   assign rem_shift = {rem_ff, div_ff[LFSR_W-1]};
   assign rem_diff  = rem_shift - {1'b0, count_ff};
   assign rem_in    = (rem_shift >= {1'b0, count_ff}) ? rem_diff[COUNT_W-1:0]
                                                      : rem_shift[COUNT_W-1:0];

   assign idx_inc     = COUNT_W'(idx_ff) + COUNT_W'(1);
   assign next_idx_in = (idx_inc == count_ff) ? '0 : idx_inc[PATH_IDX_W-1:0];

   assign route_ok = (op_ff == OP_ROUTE) && (stat_ff == STATUS_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lfsr_ff      <= LFSR_W'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.append_step) count_ff <= count_ff + COUNT_W'(1);
         // A zero seed would lock the LFSR up, so it loads as one.
         if (csr_write) begin
            lfsr_ff <= (csr_seed == '0) ? LFSR_W'(1) : csr_seed;
         end else if (cmd.lookup && !stat.empty && !flow_rd_ff.valid) begin
            lfsr_ff <= lfsr_adv_in;
         end
         if (cmd.clear_step) clr_ff <= clr_ff + FLOW_W'(1);
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_opcode;
         flow_ff   <= req_data.flow_id;
         addr_ff   <= req_data.address;
         copies_ff <= copies_in;
         known_ff  <= 1'b0;
         idx_ff    <= '0;
         stat_ff   <= (req_opcode == OP_APPEND && trunc_in) ? STATUS_TRUNC : STATUS_OK;
      end
      if (cmd.append_step) copies_ff <= copies_ff - COUNT_W'(1);
      if (cmd.lookup) begin
         if (stat.empty) begin
            stat_ff <= STATUS_EMPTY;
         end else if (flow_rd_ff.valid) begin
            idx_ff   <= flow_rd_ff.idx;
            known_ff <= 1'b1;
         end else begin
            div_ff     <= lfsr_adv_in;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         div_ff     <= div_ff << 1;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         if (stat.div_last) idx_ff <= rem_in[PATH_IDX_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.pad          <= '0;
         rsp_data_ff.list_length  <= count_ff;
         rsp_data_ff.status       <= stat_ff;
         rsp_data_ff.flow_known   <= route_ok ? known_ff : 1'b0;
         rsp_data_ff.path_index   <= route_ok ? idx_ff : '0;
         rsp_data_ff.core_address <= route_ok ? path_rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append_step) path_mem[count_ff[PATH_IDX_W-1:0]] <= addr_ff;
      path_rd_ff <= path_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         flow_mem[clr_ff] <= '0;
      end else if (cmd.path_read) begin
         flow_mem[flow_ff] <= flow_entry_type'{valid: 1'b1, idx: next_idx_in};
      end
      flow_rd_ff <= flow_mem[flow_ff];
   end

   assign stat.clear_last  = (clr_ff == FLOW_W'(FLOW_ENTRIES - 1));
   assign stat.empty       = (count_ff == '0);
   assign stat.known       = flow_rd_ff.valid;
   assign stat.div_last    = (div_cnt_ff == DIV_CNT_W'(LFSR_W - 1));
   assign stat.copies_zero = (copies_ff == '0);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/per_flow_round_robin_path_select.sv
// Per-flow round-robin path selector. After reset the block clears all FLOW_ENTRIES (1024)
// entries of its flow table and takes no request meanwhile; seed writes are taken at any
// time. Requests are handled one at a time. An append writes the path list once per copy
// that fits. A route of a known flow reads the flow table, reads the path list, writes the
// flow table and hands off the result; a route on an empty list skips the path-list read
// and the flow-table write; a route of a new flow takes as start index the LFSR value
// reduced modulo the list length by a remainder unit that retires one dividend bit per
// cycle. The result sits in an output register, so the next request is taken while a
// result still waits. Depends on pfrr_pkg, pfrr_ctrl and pfrr_dpath.
`timescale 1ns / 1ps
`default_nettype none

module per_flow_round_robin_path_select (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // flow_id, weight, address, zero padding
   input  logic [pfrr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // core_address, path_index, flow_known, status, list_length, zero padding
   output logic [pfrr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfrr_pkg::LFSR_W-1:0]        csr_data
);
   import pfrr_pkg::*;

   req_data_type req_data;
   opcode_type   req_opcode;
   rsp_data_type rsp_data;
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign req_data   = req_data_type'(req_tdata);
   assign req_opcode = opcode_type'(req_tuser);
   assign rsp_tdata  = rsp_data;
   assign csr_ready  = 1'b1;

   pfrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   pfrr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_opcode (req_opcode),
      .req_data   (req_data),
      .csr_write  (csr_valid && csr_ready),
      .csr_seed   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   // An accepted request keeps the block busy, so requests are never accepted back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   // An empty-list status can only come with an empty list.
   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.status == STATUS_EMPTY |-> rsp_data.list_length == '0)
      else $error("empty status with nonzero list length");

   // A stored next index always points inside the list.
   a_known_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data.flow_known |->
         COUNT_W'(rsp_data.path_index) < rsp_data.list_length)
      else $error("known flow returned an index beyond the list");
`endif

endmodule

`default_nettype wire
